// ===== rtl/eft_pkg.sv =====
// shared constants and helpers for the escaped frame transmitter
package eft_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NUM_SLOTS = 6;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [NUM_SLOTS-1:0] t_slots;

    localparam t_byte STX_BYTE   = 8'h02;
    localparam t_byte CR_BYTE    = 8'h0D;
    localparam t_byte ESC_BYTE   = 8'h07;
    localparam t_byte ESC_STX    = 8'h30;
    localparam t_byte ESC_CR     = 8'h31;
    localparam t_byte ESC_ESC    = 8'h32;
    localparam t_byte DIGIT_BASE = 8'h30;

    // output byte slots of one payload item, in line order
    localparam int unsigned SLOT_STX  = 0;
    localparam int unsigned SLOT_DATA = 1;
    localparam int unsigned SLOT_ESC2 = 2;
    localparam int unsigned SLOT_HI   = 3;
    localparam int unsigned SLOT_LO   = 4;
    localparam int unsigned SLOT_CR   = 5;

    function automatic logic needs_escape(input t_byte b);
        return (b == STX_BYTE) || (b == CR_BYTE) || (b == ESC_BYTE);
    endfunction

    // second byte of an escape pair
    function automatic t_byte escape_code(input t_byte b);
        t_byte code;
        unique case (1'b1)
            (b == STX_BYTE): code = ESC_STX;
            (b == CR_BYTE):  code = ESC_CR;
            default:         code = ESC_ESC;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/escaped_frame_transmitter.sv =====
// escaped frame transmitter: stx, byte escaping, ascii checksum and cr framing
//
// channel | dir | tdata             | tlast
// s_axis  | in  | [7:0] data_byte   | last_byte
// m_axis  | out | [7:0] line_byte   | frame_end
//
// one line byte leaves per cycle from a single output register while m_axis is not stalled
// a payload item sends stx when it opens a frame, one or two data bytes, on the last byte
// two checksum digits and cr; a plain mid-frame byte sends one data byte, an escaped one two
// the next item is taken in the cycle the current item's final byte is sent
// i_rst_n is synchronous; it clears frame state and the held and output valid flags
// a stall on m_axis holds the output byte and backs up into s_axis
module escaped_frame_transmitter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  eft_pkg::t_byte       i_s_tdata,   // [7:0] data_byte
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output eft_pkg::t_byte       o_m_tdata,   // [7:0] line_byte
    output logic                 o_m_tlast
);
    import eft_pkg::*;

    // frame state
    logic   r_inside;
    t_byte  r_sum;

    // held item
    logic   r_hold_valid;
    t_slots r_pend;
    t_byte  r_data;
    t_byte  r_chk;

    // output register
    logic   r_out_valid;
    t_byte  r_out_byte;
    logic   r_out_end;

    logic   s_accept;
    logic   out_free;
    logic   take;
    t_slots n_sel;
    t_slots n_pend_left;
    t_byte  n_byte;
    t_byte  n_sum;
    t_slots n_pend;

    assign out_free    = !r_out_valid || i_m_tready;
    assign take        = r_hold_valid && out_free;
    assign n_sel       = r_pend & (~r_pend + t_slots'(1));
    assign n_pend_left = r_pend & ~n_sel;
    assign o_s_tready  = !r_hold_valid || (take && (n_pend_left == '0));
    assign s_accept    = i_s_tvalid && o_s_tready;

    assign n_sum = (r_inside ? r_sum : '0) + i_s_tdata;

    always_comb begin
        n_pend = '0;
        n_pend[SLOT_STX]  = !r_inside;
        n_pend[SLOT_DATA] = 1'b1;
        n_pend[SLOT_ESC2] = needs_escape(i_s_tdata);
        n_pend[SLOT_HI]   = i_s_tlast;
        n_pend[SLOT_LO]   = i_s_tlast;
        n_pend[SLOT_CR]   = i_s_tlast;
    end

    always_comb begin
        priority if (n_sel[SLOT_STX]) begin
            n_byte = STX_BYTE;
        end else if (n_sel[SLOT_DATA]) begin
            n_byte = needs_escape(r_data) ? ESC_BYTE : r_data;
        end else if (n_sel[SLOT_ESC2]) begin
            n_byte = escape_code(r_data);
        end else if (n_sel[SLOT_HI]) begin
            n_byte = DIGIT_BASE + {4'h0, r_chk[7:4]};
        end else if (n_sel[SLOT_LO]) begin
            n_byte = DIGIT_BASE + {4'h0, r_chk[3:0]};
        end else begin
            n_byte = CR_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_sum        <= '0;
            r_hold_valid <= 1'b0;
            r_pend       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_pend <= n_pend_left;
                if (n_pend_left == '0) begin
                    r_hold_valid <= 1'b0;
                end
            end
            if (s_accept) begin
                r_hold_valid <= 1'b1;
                r_pend       <= n_pend;
                // a closing byte returns the frame state to idle
                r_inside     <= !i_s_tlast;
                r_sum        <= i_s_tlast ? '0 : n_sum;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_data <= i_s_tdata;
            r_chk  <= n_sum;
        end
        if (take) begin
            r_out_byte <= n_byte;
            r_out_end  <= n_sel[SLOT_CR];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_end;

    a_end_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == CR_BYTE))
        else $error("frame end flagged on a byte other than cr");

    a_hold_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_pend != '0))
        else $error("held item has no bytes left to send");

    a_open_sends_stx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !r_inside) |=> (r_pend[SLOT_STX] && r_pend[SLOT_DATA]))
        else $error("frame opened without stx slot");

endmodule
